@@ hw/rtl/lkt_pkg.sv @@
// Shared types and constants for the LRU key tracker.
package lkt_pkg;
	localparam int unsigned MaxEntries = 16;
	localparam int unsigned KeyBits = 32;
	localparam int unsigned IdxW = $clog2(MaxEntries);
	localparam int unsigned CntW = $clog2(MaxEntries + 1);
	localparam int unsigned CapW = 5;
	localparam logic [CapW-1:0] CapReset = CapW'(MaxEntries);

	localparam logic OpRefer = 1'b0;
	localparam logic OpList = 1'b1;

	typedef struct packed {
		logic latch_in;   // capture the input word
		logic do_refer;   // apply the refer update
		logic list_load;  // load the list rank counter
		logic list_step;  // advance the list rank
	} lkt_cmd_t;

	typedef struct packed {
		logic list_done;  // current listed rank is the final one
		logic empty;      // no key held
	} lkt_sts_t;

	typedef struct packed {
		logic hit;
		logic evicted;
		logic [KeyBits-1:0] evicted_key;
		logic [KeyBits-1:0] listed_key;
		logic list_valid;
		logic last;
	} lkt_res_t;
endpackage

@@ hw/rtl/lru_key_tracker_top.sv @@
// Top level of the LRU key tracker.
//   channel  dir  handshake       content
//   s_axis   in   tvalid/tready   tuser op, tdata key
//   m_axis   out  tvalid/tready   tdata result, tlast
//   cfg      in   cfg_we          capacity
// A refer is accepted in StIdle, then compared and rank-updated in StRefer once the output is free.
// A list gives one result per held key (one per cycle unless m_axis stalls), one if empty.
// The result register lets the next word enter while a result waits.
// A stalled m_axis_tready holds the controller; arst_n clears state and valid flags,
// the key store itself is not reset.
module lru_key_tracker_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata, // [31:0] key
	input  logic s_axis_tuser,        // [0] op
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [71:0] m_axis_tdata, // [0] hit, [1] evicted, [33:2] evicted_key,
	                                  // [65:34] listed_key, [66] list_valid
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [lkt_pkg::CapW-1:0] cfg_wdata
);
	import lkt_pkg::*;

	logic [CapW-1:0] cap_q;
	logic out_free;
	logic res_load;
	logic in_ready;
	lkt_cmd_t cmd;
	lkt_sts_t sts;
	lkt_res_t res;
	lkt_res_t res_q;
	logic ovalid_q;

	assign out_free = !ovalid_q || m_axis_tready;
	assign s_axis_tready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (res_load) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	lkt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && in_ready), .op_in(s_axis_tuser),
		.out_free(out_free), .in_ready(in_ready), .res_load(res_load),
		.cmd(cmd), .sts(sts)
	);

	lkt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op_in(s_axis_tuser), .key_in(s_axis_tdata),
		.capacity(cap_q), .res(res)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tlast = res_q.last;
	assign m_axis_tdata = {5'd0, res_q.list_valid, res_q.listed_key,
		res_q.evicted_key, res_q.evicted, res_q.hit};
endmodule

@@ hw/rtl/lkt_datapath.sv @@
// Key store, recency ranks, hit compare and result formation.
module lkt_datapath (
	input  logic clk,
	input  logic arst_n,
	input  lkt_pkg::lkt_cmd_t cmd,
	output lkt_pkg::lkt_sts_t sts,
	input  logic op_in,
	input  logic [lkt_pkg::KeyBits-1:0] key_in,
	input  logic [lkt_pkg::CapW-1:0] capacity,
	output lkt_pkg::lkt_res_t res
);
	import lkt_pkg::*;

	logic [KeyBits-1:0] key_q;
	logic op_q;
	logic [KeyBits-1:0] store_q [MaxEntries];
	logic [MaxEntries-1:0] valid_q;
	logic [IdxW-1:0] rank_q [MaxEntries];
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] lrank_q;

	logic [MaxEntries-1:0] match;
	logic [MaxEntries-1:0] lru_sel;
	logic [MaxEntries-1:0] list_sel;
	logic hit;
	logic [IdxW-1:0] hit_rank;
	logic [CntW-1:0] eff_cap;
	logic do_evict;
	logic [IdxW-1:0] evict_idx;
	logic [IdxW-1:0] free_idx;
	logic [IdxW-1:0] new_idx;
	logic [KeyBits-1:0] ev_key;
	logic [KeyBits-1:0] lst_key;

	always_comb begin
		if (capacity == '0) eff_cap = CntW'(1);
		else if (capacity > CapW'(MaxEntries)) eff_cap = CntW'(MaxEntries);
		else eff_cap = CntW'(capacity);
	end

	always_comb begin
		hit_rank = '0;
		evict_idx = '0;
		free_idx = '0;
		ev_key = '0;
		lst_key = '0;
		for (int i = MaxEntries - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (store_q[i] == key_q);
			lru_sel[i] = valid_q[i] && (CntW'(rank_q[i]) == count_q - CntW'(1));
			list_sel[i] = valid_q[i] && (rank_q[i] == lrank_q);
			if (match[i]) hit_rank = rank_q[i];
			if (lru_sel[i]) begin
				evict_idx = IdxW'(i);
				ev_key = store_q[i];
			end
			if (!valid_q[i]) free_idx = IdxW'(i);
			if (list_sel[i]) lst_key = store_q[i];
		end
		hit = |match;
		do_evict = !hit && (count_q != '0) && (count_q >= eff_cap);
		new_idx = do_evict ? evict_idx : free_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			key_q <= key_in;
			op_q <= op_in;
		end
		if (cmd.do_refer && !hit) store_q[new_idx] <= key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			lrank_q <= '0;
			for (int i = 0; i < MaxEntries; i++) rank_q[i] <= '0;
		end else begin
			if (cmd.list_load) lrank_q <= '0;
			else if (cmd.list_step) lrank_q <= lrank_q + IdxW'(1);
			if (cmd.do_refer) begin
				for (int i = 0; i < MaxEntries; i++) begin
					if (hit) begin
						if (match[i]) rank_q[i] <= '0;
						else if (valid_q[i] && rank_q[i] < hit_rank)
							rank_q[i] <= rank_q[i] + IdxW'(1);
					end else begin
						if (IdxW'(i) == new_idx) rank_q[i] <= '0;
						else if (valid_q[i]) rank_q[i] <= rank_q[i] + IdxW'(1);
					end
				end
				if (!hit) begin
					valid_q[new_idx] <= 1'b1;
					// an eviction frees and refills the same entry
					if (!do_evict) count_q <= count_q + CntW'(1);
				end
			end
		end
	end

	assign sts.empty = (count_q == '0);
	assign sts.list_done = (CntW'(lrank_q) + CntW'(1) >= count_q);

	always_comb begin
		res = '0;
		res.last = 1'b1;
		if (op_q == OpRefer) begin
			res.hit = hit;
			res.evicted = do_evict;
			res.evicted_key = do_evict ? ev_key : '0;
		end else if (!sts.empty) begin
			res.listed_key = lst_key;
			res.list_valid = 1'b1;
			res.last = sts.list_done;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxEntries)) else $error("held count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q)) else $error("count mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match)) else $error("duplicate key held");
endmodule

@@ hw/rtl/lkt_ctrl.sv @@
// Controller sequencing refer and list words.
module lkt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic op_in,
	input  logic out_free,
	output logic in_ready,
	output logic res_load,
	output lkt_pkg::lkt_cmd_t cmd,
	input  lkt_pkg::lkt_sts_t sts
);
	import lkt_pkg::*;

	typedef enum logic [2:0] {
		StIdle  = 3'b001,
		StRefer = 3'b010,
		StList  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		res_load = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			StIdle: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.latch_in = 1'b1;
					cmd.list_load = 1'b1;
					state_d = (op_in == OpList) ? StList : StRefer;
				end
			end
			StRefer: begin
				if (out_free) begin
					cmd.do_refer = 1'b1;
					res_load = 1'b1;
					state_d = StIdle;
				end
			end
			StList: begin
				if (out_free) begin
					res_load = 1'b1;
					cmd.list_step = 1'b1;
					if (sts.empty || sts.list_done) state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= StIdle;
		else state_q <= state_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == StIdle) else $error("accept while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StRefer && out_free) |=> state_q == StIdle)
		else $error("refer not finished");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free) else $error("result overwritten");
endmodule
